// File: design/particle_euler_integrator_top_assert.svh
// assertion macros for the particle integrator
// expects clk and rst in the scope of each use
`ifndef PARTICLE_EULER_INTEGRATOR_TOP_ASSERT_SVH
`define PARTICLE_EULER_INTEGRATOR_TOP_ASSERT_SVH
`ifndef SYNTH
`define PEI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pei assertion failed");
`define PEI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pei assertion failed");
`else
`define PEI_ASSERT_NOW(label, ante, cons)
`define PEI_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: design/pei_pkg.sv
// shared types and constants of the particle integrator
// no dependencies
`timescale 1ns / 1ps
package pei_pkg;

  localparam int WORD_W    = 32;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 3;
  localparam int MASS_W    = 31;
  localparam int DAMP_W    = 17;
  localparam int STEP_W    = 31;
  localparam int LANES     = 3;

  typedef logic signed [WORD_W-1:0]   word_t;
  typedef logic signed [2*WORD_W-1:0] prod_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  // opcodes
  localparam logic [OP_W-1:0] OP_ADD_FORCE = 2'd0;
  localparam logic [OP_W-1:0] OP_INTEGRATE = 2'd1;
  localparam logic [OP_W-1:0] OP_SET_POS   = 2'd2;
  localparam logic [OP_W-1:0] OP_SET_VEL   = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INV_MASS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_Z  = 3'd5;

  localparam logic [MASS_W-1:0] INV_MASS_RST = 31'd0;
  localparam logic [DAMP_W-1:0] DAMPING_RST  = 17'd65536;
  localparam logic [STEP_W-1:0] STEP_RST     = 31'd1092;

  // multiplier operand pairs
  localparam logic [1:0] MUL_VEL_TS = 2'd0;
  localparam logic [1:0] MUL_FRC_IM = 2'd1;
  localparam logic [1:0] MUL_ACC_TS = 2'd2;
  localparam logic [1:0] MUL_NV_DMP = 2'd3;

  // what to do with the product register
  localparam logic [2:0] POST_NONE = 3'd0;
  localparam logic [2:0] POST_POS  = 3'd1;
  localparam logic [2:0] POST_ACC  = 3'd2;
  localparam logic [2:0] POST_NV   = 3'd3;
  localparam logic [2:0] POST_VEL  = 3'd4;

  typedef struct packed {
    logic       latch;
    logic       apply;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic [2:0] post_sel;
    logic       load_out;
  } pei_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            im_zero;
  } pei_status_t;

  typedef struct packed {
    word_t val;
    logic  ovf;
  } sat_word_t;

endpackage

// File: design/pei_if.sv
// stream channels of the particle integrator: command beats in, state beats out
// depends on pei_pkg
`timescale 1ns / 1ps
interface pei_in_if import pei_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] opcode;
  word_t           vec_x;
  word_t           vec_y;
  word_t           vec_z;

  modport source (output valid, opcode, vec_x, vec_y, vec_z, input ready);
  modport sink   (input valid, opcode, vec_x, vec_y, vec_z, output ready);
endinterface

interface pei_out_if import pei_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t pos_x;
  word_t pos_y;
  word_t pos_z;
  word_t vel_x;
  word_t vel_y;
  word_t vel_z;
  logic  saturated;

  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, saturated,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, saturated,
                  output ready);
endinterface

// File: design/pei_ctrl.sv
// sequencer of the particle integrator: handshakes and step schedule
// depends on pei_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "particle_euler_integrator_top_assert.svh"
module pei_ctrl import pei_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  pei_status_t status,
  output pei_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_MUL_POS  = 4'd2;
  localparam logic [3:0] S_MUL_FRC  = 4'd3;
  localparam logic [3:0] S_POST_ACC = 4'd4;
  localparam logic [3:0] S_MUL_ACC  = 4'd5;
  localparam logic [3:0] S_POST_NV  = 4'd6;
  localparam logic [3:0] S_MUL_DMP  = 4'd7;
  localparam logic [3:0] S_POST_VEL = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_free;

  // no beat is taken while reset is held
  assign in_ready = (state == S_IDLE) && !rst;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.post_sel = POST_NONE;
    cmd.mul_sel  = MUL_VEL_TS;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status.op == OP_INTEGRATE) begin
          // immovable particle skips straight to the result
          state_next = status.im_zero ? S_DONE : S_MUL_POS;
        end else begin
          cmd.apply  = 1'b1;
          state_next = S_DONE;
        end
      end
      S_MUL_POS: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_VEL_TS;
        state_next  = S_MUL_FRC;
      end
      S_MUL_FRC: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_FRC_IM;
        cmd.post_sel = POST_POS;
        state_next   = S_POST_ACC;
      end
      S_POST_ACC: begin
        cmd.post_sel = POST_ACC;
        state_next   = S_MUL_ACC;
      end
      S_MUL_ACC: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ACC_TS;
        state_next  = S_POST_NV;
      end
      S_POST_NV: begin
        cmd.post_sel = POST_NV;
        state_next   = S_MUL_DMP;
      end
      S_MUL_DMP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_NV_DMP;
        state_next  = S_POST_VEL;
      end
      S_POST_VEL: begin
        cmd.post_sel = POST_VEL;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `PEI_ASSERT_NEXT(a_load_shows_beat, cmd.load_out, out_valid)
  `PEI_ASSERT_NEXT(a_latch_then_decode, cmd.latch, state == S_DECODE)
  `PEI_ASSERT_NOW(a_load_only_when_free, cmd.load_out, !out_valid || out_ready)
  `PEI_ASSERT_NOW(a_apply_alone, cmd.apply, !cmd.mul_en && cmd.post_sel == POST_NONE)

endmodule

// File: design/pei_datapath.sv
// datapath of the particle integrator: config registers, state, three axis lanes
// each lane has one multiplier; depends on pei_pkg
`timescale 1ns / 1ps
module pei_datapath import pei_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  input  logic [OP_W-1:0]      in_opcode,
  input  word_t                in_vec_x,
  input  word_t                in_vec_y,
  input  word_t                in_vec_z,
  input  pei_cmd_t             cmd,
  output pei_status_t          status,
  output word_t                pos_x,
  output word_t                pos_y,
  output word_t                pos_z,
  output word_t                vel_x,
  output word_t                vel_y,
  output word_t                vel_z,
  output logic                 saturated
);

  localparam prod_t HALF = prod_t'(1) <<< (FRAC_BITS - 1);

  logic [MASS_W-1:0] inv_mass;
  logic [DAMP_W-1:0] damping;
  logic [STEP_W-1:0] time_step;
  word_t             accel [LANES];

  logic [OP_W-1:0] op;
  word_t           vec   [LANES];
  word_t           pos   [LANES];
  word_t           vel   [LANES];
  word_t           frc   [LANES];
  word_t           tmp   [LANES];
  prod_t           prod  [LANES];
  logic            sat_flag;

  word_t             pos_next [LANES];
  word_t             vel_next [LANES];
  word_t             frc_next [LANES];
  word_t             tmp_next [LANES];
  word_t             mul_a    [LANES];
  logic [STEP_W-1:0] mul_b;
  logic              ovf_any;

  sat_word_t rnd   [LANES];
  sat_word_t s_pos [LANES];
  sat_word_t s_acc [LANES];
  sat_word_t s_nv  [LANES];
  sat_word_t s_frc [LANES];

  function automatic sat_word_t sat_add(input word_t a, input word_t b);
    logic [WORD_W:0] s;
    sat_word_t       r;
    s     = {a[WORD_W-1], a} + {b[WORD_W-1], b};
    r.ovf = s[WORD_W] ^ s[WORD_W-1];
    r.val = r.ovf ? (s[WORD_W] ? WORD_MIN : WORD_MAX) : word_t'(s[WORD_W-1:0]);
    return r;
  endfunction

  // round to nearest, ties up, then clamp to one word
  function automatic sat_word_t sat_round(input prod_t p);
    prod_t     q;
    sat_word_t r;
    q     = (p + HALF) >>> FRAC_BITS;
    r.ovf = !((&q[2*WORD_W-1:WORD_W-1]) || !(|q[2*WORD_W-1:WORD_W-1]));
    r.val = r.ovf ? (q[2*WORD_W-1] ? WORD_MIN : WORD_MAX) : word_t'(q[WORD_W-1:0]);
    return r;
  endfunction

  assign status.op      = op;
  assign status.im_zero = (inv_mass == '0);

  always_comb begin
    case (cmd.mul_sel)
      MUL_VEL_TS: mul_b = time_step;
      MUL_FRC_IM: mul_b = inv_mass;
      MUL_ACC_TS: mul_b = time_step;
      MUL_NV_DMP: mul_b = STEP_W'(damping);
      default:    mul_b = time_step;
    endcase
  end

  always_comb begin
    ovf_any = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      case (cmd.mul_sel)
        MUL_VEL_TS: mul_a[i] = vel[i];
        MUL_FRC_IM: mul_a[i] = frc[i];
        default:    mul_a[i] = tmp[i];
      endcase

      rnd[i]   = sat_round(prod[i]);
      s_pos[i] = sat_add(pos[i], rnd[i].val);
      s_acc[i] = sat_add(accel[i], rnd[i].val);
      s_nv[i]  = sat_add(vel[i], rnd[i].val);
      s_frc[i] = sat_add(frc[i], vec[i]);

      pos_next[i] = pos[i];
      vel_next[i] = vel[i];
      frc_next[i] = frc[i];
      tmp_next[i] = tmp[i];

      case (cmd.post_sel)
        POST_POS: begin
          pos_next[i] = s_pos[i].val;
          ovf_any     = ovf_any | rnd[i].ovf | s_pos[i].ovf;
        end
        POST_ACC: begin
          tmp_next[i] = s_acc[i].val;
          ovf_any     = ovf_any | rnd[i].ovf | s_acc[i].ovf;
        end
        POST_NV: begin
          tmp_next[i] = s_nv[i].val;
          ovf_any     = ovf_any | rnd[i].ovf | s_nv[i].ovf;
        end
        POST_VEL: begin
          vel_next[i] = rnd[i].val;
          frc_next[i] = '0;
          ovf_any     = ovf_any | rnd[i].ovf;
        end
        default: ;
      endcase

      if (cmd.apply) begin
        case (op)
          OP_ADD_FORCE: begin
            frc_next[i] = s_frc[i].val;
            ovf_any     = ovf_any | s_frc[i].ovf;
          end
          OP_SET_POS: pos_next[i] = vec[i];
          OP_SET_VEL: vel_next[i] = vec[i];
          default: ;
        endcase
      end
    end
  end

  // configuration and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_mass  <= INV_MASS_RST;
      damping   <= DAMPING_RST;
      time_step <= STEP_RST;
      for (int i = 0; i < LANES; i++) begin
        accel[i] <= '0;
        pos[i]   <= '0;
        vel[i]   <= '0;
        frc[i]   <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INV_MASS: inv_mass  <= cfg_data[MASS_W-1:0];
          CFG_DAMPING:  damping   <= cfg_data[DAMP_W-1:0];
          CFG_STEP:     time_step <= cfg_data[STEP_W-1:0];
          CFG_ACCEL_X:  accel[0]  <= word_t'(cfg_data);
          CFG_ACCEL_Y:  accel[1]  <= word_t'(cfg_data);
          CFG_ACCEL_Z:  accel[2]  <= word_t'(cfg_data);
          default: ;
        endcase
      end
      for (int i = 0; i < LANES; i++) begin
        pos[i] <= pos_next[i];
        vel[i] <= vel_next[i];
        frc[i] <= frc_next[i];
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op       <= in_opcode;
      vec[0]   <= in_vec_x;
      vec[1]   <= in_vec_y;
      vec[2]   <= in_vec_z;
      sat_flag <= 1'b0;
    end else begin
      sat_flag <= sat_flag | ovf_any;
    end
    for (int i = 0; i < LANES; i++) begin
      tmp[i] <= tmp_next[i];
      if (cmd.mul_en) begin
        prod[i] <= mul_a[i] * $signed({1'b0, mul_b});
      end
    end
    if (cmd.load_out) begin
      pos_x     <= pos[0];
      pos_y     <= pos[1];
      pos_z     <= pos[2];
      vel_x     <= vel[0];
      vel_y     <= vel[1];
      vel_z     <= vel[2];
      saturated <= sat_flag;
    end
  end

endmodule

// File: design/particle_euler_integrator_top.sv
// channel   dir  payload                                   beat taken when
// item      in   opcode, vec_x, vec_y, vec_z               item.valid && item.ready
// result    out  pos_x..z, vel_x..z, saturated             result.valid && result.ready
// cfg       in   cfg_index, cfg_data                       cfg_we
//
// an item is taken only while the sequencer is idle; add_force, set_position,
// set_velocity and an integrate of an immovable particle go from decode straight
// to the last step; a full integrate forms four dependent products per axis lane,
// each a multiply step then a round, clamp and add step, the first two overlapped.
// the result sits in an output register; a new item is taken while it waits,
// and its own result waits in the last step until that register is free.
// rst is synchronous and clears state, config and the result valid.
// depends on pei_pkg, pei_if, pei_ctrl, pei_datapath
`timescale 1ns / 1ps
module particle_euler_integrator_top import pei_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  pei_in_if.sink               item,
  pei_out_if.source            result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  pei_cmd_t    cmd;
  pei_status_t status;

  pei_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  pei_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_opcode (item.opcode),
    .in_vec_x  (item.vec_x),
    .in_vec_y  (item.vec_y),
    .in_vec_z  (item.vec_z),
    .cmd       (cmd),
    .status    (status),
    .pos_x     (result.pos_x),
    .pos_y     (result.pos_y),
    .pos_z     (result.pos_z),
    .vel_x     (result.vel_x),
    .vel_y     (result.vel_y),
    .vel_z     (result.vel_z),
    .saturated (result.saturated)
  );

endmodule

// File: tb/tb_particle_euler_integrator_top.sv
// self-checking bench for particle_euler_integrator_top: directed and random command beats,
// state beats checked against a fixed-point euler predictor held in a scoreboard class
// depends on pei_pkg, pei_if and the integrator rtl
`timescale 1ns / 1ps
module tb_particle_euler_integrator_top import pei_pkg::*; ;
  localparam int FRAC            = 16;
  localparam int LIMIT_CYCLES    = 500000;
  localparam int DRAIN_CYCLES    = 16;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int IDLE_PCT        = 18;

  typedef struct packed {
    word_t [LANES-1:0] pos;
    word_t [LANES-1:0] vel;
    logic              sat;
  } state_beat_t;

  class pei_state_board #(int FRAC = 16);
    logic [MASS_W-1:0] inv_mass;
    logic [DAMP_W-1:0] damping;
    logic [STEP_W-1:0] step;
    word_t             accel[LANES];
    word_t             pos[LANES];
    word_t             vel[LANES];
    word_t             force_acc[LANES];
    state_beat_t       pending_states[$];
    int                errors;
    string             axis[LANES] = '{"x", "y", "z"};

    function new();
      inv_mass = INV_MASS_RST;
      damping  = DAMPING_RST;
      step     = STEP_RST;
      errors   = 0;
      foreach (pos[i]) begin
        accel[i]     = '0;
        pos[i]       = '0;
        vel[i]       = '0;
        force_acc[i] = '0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
      case (idx)
        CFG_INV_MASS: inv_mass = data[MASS_W-1:0];
        CFG_DAMPING:  damping  = data[DAMP_W-1:0];
        CFG_STEP:     step     = data[STEP_W-1:0];
        CFG_ACCEL_X:  accel[0] = data;
        CFG_ACCEL_Y:  accel[1] = data;
        CFG_ACCEL_Z:  accel[2] = data;
        default: ;
      endcase
    endfunction

    function word_t clamp(longint v, inout bit hit);
      if (v > longint'(WORD_MAX)) begin
        hit = 1'b1;
        return WORD_MAX;
      end
      if (v < longint'(WORD_MIN)) begin
        hit = 1'b1;
        return WORD_MIN;
      end
      return word_t'(v);
    endfunction

    // round to nearest, ties up, then clamp
    function word_t fmul(word_t a, longint b, inout bit hit);
      longint p;
      p = longint'(a) * b + (longint'(1) <<< (FRAC - 1));
      return clamp(p >>> FRAC, hit);
    endfunction

    function void take_command(logic [OP_W-1:0] op, word_t x, word_t y, word_t z);
      word_t       v[LANES];
      word_t       t;
      word_t       acc;
      word_t       nv;
      bit          hit;
      state_beat_t beat;
      v[0] = x;
      v[1] = y;
      v[2] = z;
      hit  = 1'b0;
      case (op)
        OP_ADD_FORCE:
          foreach (v[i]) force_acc[i] = clamp(longint'(force_acc[i]) + longint'(v[i]), hit);
        OP_INTEGRATE:
          // an immovable particle keeps everything, force sum included
          if (inv_mass != '0) begin
            foreach (v[i]) begin
              t            = fmul(vel[i], longint'(step), hit);
              pos[i]       = clamp(longint'(pos[i]) + longint'(t), hit);
              t            = fmul(force_acc[i], longint'(inv_mass), hit);
              acc          = clamp(longint'(accel[i]) + longint'(t), hit);
              t            = fmul(acc, longint'(step), hit);
              nv           = clamp(longint'(vel[i]) + longint'(t), hit);
              vel[i]       = fmul(nv, longint'(damping), hit);
              force_acc[i] = '0;
            end
          end
        OP_SET_POS:
          foreach (v[i]) pos[i] = v[i];
        OP_SET_VEL:
          foreach (v[i]) vel[i] = v[i];
        default: ;
      endcase
      foreach (v[i]) begin
        beat.pos[i] = pos[i];
        beat.vel[i] = vel[i];
      end
      beat.sat = hit;
      pending_states.push_back(beat);
    endfunction

    function void check_state(state_beat_t got);
      state_beat_t want;
      if (pending_states.size() == 0) begin
        errors++;
        $display("%0t: state beat with nothing expected: pos %h vel %h sat %b",
                 $time, got.pos, got.vel, got.sat);
        return;
      end
      want = pending_states.pop_front();
      for (int i = 0; i < LANES; i++) begin
        if (got.pos[i] !== want.pos[i]) begin
          errors++;
          $display("%0t: pos_%s expected %h actual %h", $time, axis[i], want.pos[i],
                   got.pos[i]);
        end
        if (got.vel[i] !== want.vel[i]) begin
          errors++;
          $display("%0t: vel_%s expected %h actual %h", $time, axis[i], want.vel[i],
                   got.vel[i]);
        end
      end
      if (got.sat !== want.sat) begin
        errors++;
        $display("%0t: saturated expected %b actual %b", $time, want.sat, got.sat);
      end
    endfunction
  endclass

  typedef pei_state_board #(FRAC) board_t;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
  localparam logic [OP_W-1:0] ALL_OPS[4] = '{OP_ADD_FORCE, OP_INTEGRATE, OP_SET_POS, OP_SET_VEL};

  localparam word_t ONE = 32'sh0001_0000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]    cfg_data = '0;

  bit calm_run = 1'b0;
  int hold_cycles = 0;
  int items_sent = 0;
  int cycle_count = 0;

  board_t board = new();

  pei_in_if  item_ch ();
  pei_out_if result_ch ();

  particle_euler_integrator_top #(.FRAC_BITS(FRAC)) dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when asked
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= calm_run || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : watch_results
    state_beat_t got;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      got.pos[0] = result_ch.pos_x;
      got.pos[1] = result_ch.pos_y;
      got.pos[2] = result_ch.pos_z;
      got.vel[0] = result_ch.vel_x;
      got.vel[1] = result_ch.vel_y;
      got.vel[2] = result_ch.vel_z;
      got.sat    = result_ch.saturated;
      board.check_state(got);
    end
  end

  function automatic word_t pick_word();
    case ($urandom_range(15))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2, 3:    return $urandom;
      default: return word_t'(int'($urandom_range(1310720)) - 655360);
    endcase
  endfunction

  task automatic send_item(logic [OP_W-1:0] op, word_t x, word_t y, word_t z);
    while (!calm_run && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      item_ch.valid <= 1'b0;
    end
    @(negedge clk);
    item_ch.valid  <= 1'b1;
    item_ch.opcode <= op;
    item_ch.vec_x  <= x;
    item_ch.vec_y  <= y;
    item_ch.vec_z  <= z;
    @(posedge clk);
    while (item_ch.ready !== 1'b1) @(posedge clk);
    board.take_command(op, x, y, z);
    items_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.write_reg(idx, data);
  endtask

  // stop offering beats and let every pending state beat come back
  task automatic settle();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (board.pending_states.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic shake_config();
    case ($urandom_range(7))
      0:       write_reg(CFG_INV_MASS, '0);
      1:       write_reg(CFG_INV_MASS, 32'hFFFF_FFFF);
      default: write_reg(CFG_INV_MASS, $urandom_range(32'h0004_0000, 32'h0000_1000));
    endcase
    case ($urandom_range(7))
      0:       write_reg(CFG_DAMPING, '0);
      1:       write_reg(CFG_DAMPING, 32'h0001_FFFF);
      2:       write_reg(CFG_DAMPING, 32'h0001_0000);
      3:       write_reg(CFG_DAMPING, $urandom_range(131071, 65537));
      default: write_reg(CFG_DAMPING, $urandom_range(65536, 58982));
    endcase
    case ($urandom_range(7))
      0:       write_reg(CFG_STEP, '0);
      1:       write_reg(CFG_STEP, 32'h7FFF_FFFF);
      2:       write_reg(CFG_STEP, $urandom);
      default: write_reg(CFG_STEP, $urandom_range(6554, 64));
    endcase
    write_reg(CFG_ACCEL_X, pick_word());
    write_reg(CFG_ACCEL_Y, pick_word());
    write_reg(CFG_ACCEL_Z, pick_word());
    if ($urandom_range(3) == 0)
      write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom);
  endtask

  // mostly forces followed by an integrate, some loads, some noise
  task automatic run_sequence();
    int roll;
    roll = $urandom_range(99);
    if (roll < 15) begin
      send_item(ALL_OPS[$urandom_range(3)], $urandom, $urandom, $urandom);
    end else begin
      if (roll < 25)
        send_item(OP_SET_POS, pick_word(), pick_word(), pick_word());
      else if (roll < 35)
        send_item(OP_SET_VEL, pick_word(), pick_word(), pick_word());
      repeat ($urandom_range(3)) send_item(OP_ADD_FORCE, pick_word(), pick_word(), pick_word());
      send_item(OP_INTEGRATE, pick_word(), pick_word(), pick_word());
    end
  endtask

  initial begin : main
    int  goal;
    bit  paused;
    item_ch.valid  = 1'b0;
    item_ch.opcode = OP_ADD_FORCE;
    item_ch.vec_x  = '0;
    item_ch.vec_y  = '0;
    item_ch.vec_z  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset config: inverse mass zero, so the particle is immovable
    send_item(OP_ADD_FORCE, ONE, -2 * ONE, 32'sh0000_8000);
    send_item(OP_INTEGRATE, '0, '0, '0);
    send_item(OP_SET_POS, WORD_MAX, WORD_MIN, '0);
    send_item(OP_SET_VEL, WORD_MIN, WORD_MAX, ONE);
    settle();

    write_reg(CFG_INV_MASS, ONE);
    write_reg(CFG_DAMPING, 32'd62259);
    write_reg(CFG_STEP, 32'd6554);
    write_reg(CFG_ACCEL_X, '0);
    write_reg(CFG_ACCEL_Y, 32'hFFF6_3334);
    write_reg(CFG_ACCEL_Z, '0);
    write_reg(CFG_SPARE_A, 32'h1234_5678);
    // force kept from the immovable integrate gets used here
    send_item(OP_INTEGRATE, '0, '0, '0);
    send_item(OP_ADD_FORCE, WORD_MAX, WORD_MAX, WORD_MIN);
    send_item(OP_ADD_FORCE, WORD_MAX, 32'sd1, -32'sd1);
    send_item(OP_INTEGRATE, WORD_MAX, WORD_MIN, '0);
    send_item(OP_SET_POS, '0, '0, '0);
    send_item(OP_SET_VEL, ONE, '0, -ONE);
    send_item(OP_ADD_FORCE, 32'sh0000_8000, -32'sh0000_8000, 32'sh0003_0000);
    send_item(OP_INTEGRATE, '0, '0, '0);
    send_item(OP_INTEGRATE, '0, '0, '0);
    settle();

    // zero step, damping above one, masked inverse mass, extreme acceleration
    write_reg(CFG_STEP, '0);
    write_reg(CFG_DAMPING, 32'h0001_FFFF);
    write_reg(CFG_INV_MASS, 32'hFFFF_FFFF);
    write_reg(CFG_ACCEL_X, WORD_MAX);
    write_reg(CFG_ACCEL_Y, WORD_MIN);
    write_reg(CFG_ACCEL_Z, 32'h0000_7FFF);
    write_reg(CFG_SPARE_B, 32'hFFFF_FFFF);
    send_item(OP_SET_VEL, 3 * ONE, -3 * ONE, WORD_MAX);
    send_item(OP_ADD_FORCE, ONE, WORD_MIN, 32'sd1);
    send_item(OP_INTEGRATE, '0, '0, '0);
    send_item(OP_INTEGRATE, '0, '0, '0);
    settle();

    // huge step, damping zero
    write_reg(CFG_STEP, 32'h7FFF_FFFF);
    write_reg(CFG_DAMPING, '0);
    write_reg(CFG_INV_MASS, 32'd1);
    write_reg(CFG_ACCEL_X, '0);
    write_reg(CFG_ACCEL_Y, '0);
    write_reg(CFG_ACCEL_Z, '0);
    send_item(OP_SET_VEL, ONE, -ONE, 32'sh0000_0100);
    send_item(OP_INTEGRATE, '0, '0, '0);
    send_item(OP_ADD_FORCE, -ONE, WORD_MAX, WORD_MIN);
    send_item(OP_INTEGRATE, '0, '0, '0);

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      shake_config();
      calm_run = (phase == 2);
      if (phase == 4 || phase == 6)
        hold_cycles = 200;
      goal   = items_sent + ITEMS_PER_PHASE;
      paused = 1'b0;
      while (items_sent < goal) begin
        // sender waits for every state beat halfway through this phase
        if (phase == 5 && !paused && items_sent > goal - ITEMS_PER_PHASE / 2) begin
          paused = 1'b1;
          settle();
        end
        run_sequence();
      end
    end
    calm_run = 1'b0;
    settle();

    if (board.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
